[src/kmjr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmjr_pkg
// Shared types, opcodes and the key position table for the keyboard matrix.
// ----------------------------------------------------------------------------
package kmjr_pkg;

  localparam int unsigned NUM_ROWS = 8;
  localparam int unsigned NUM_COLS = 5;
  localparam int unsigned NUM_KEYS = 40;
  localparam int unsigned NUM_BTNS = 5;
  localparam int unsigned MAP_W    = 30;
  localparam int unsigned KEY_W    = 6;

  localparam logic [NUM_COLS-1:0] ROW_MASK = 5'h1f;

  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_STICK = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_STICK0 = 1'b0;
  localparam logic CFG_STICK1 = 1'b1;

  localparam logic [MAP_W-1:0] STICK0_MAP_RST = 30'd644392473;
  localparam logic [MAP_W-1:0] STICK1_MAP_RST = 30'd1859912;

  // {row[2:0], col[2:0]} for every key
  localparam logic [5:0] KEY_POS [NUM_KEYS] = '{
    {3'd4, 3'd0}, {3'd3, 3'd0}, {3'd3, 3'd1}, {3'd3, 3'd2}, {3'd3, 3'd3},
    {3'd3, 3'd4}, {3'd4, 3'd4}, {3'd4, 3'd3}, {3'd4, 3'd2}, {3'd4, 3'd1},
    {3'd1, 3'd0}, {3'd7, 3'd4}, {3'd0, 3'd3}, {3'd1, 3'd2}, {3'd2, 3'd2},
    {3'd1, 3'd3}, {3'd1, 3'd4}, {3'd6, 3'd4}, {3'd5, 3'd2}, {3'd6, 3'd3},
    {3'd6, 3'd2}, {3'd6, 3'd1}, {3'd7, 3'd2}, {3'd7, 3'd3}, {3'd5, 3'd1},
    {3'd5, 3'd0}, {3'd2, 3'd0}, {3'd2, 3'd3}, {3'd1, 3'd1}, {3'd2, 3'd4},
    {3'd5, 3'd3}, {3'd0, 3'd4}, {3'd2, 3'd1}, {3'd0, 3'd2}, {3'd5, 3'd4},
    {3'd0, 3'd1}, {3'd0, 3'd0}, {3'd7, 3'd1}, {3'd7, 3'd0}, {3'd6, 3'd0}
  };

  // Key update request from the remap logic to the row store
  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] key;
    logic             down;
  } key_upd_t;

endpackage

[src/keyboard_matrix_with_joystick_remap_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_matrix_with_joystick_remap_unit
// 8x5 active-low keyboard matrix with a two-stick remappable joystick front.
// ----------------------------------------------------------------------------
// Throughput: one event per cycle, set by the single event stage register,
//   while no read is held there by a full result register. A read returns
//   key_data via the event register, then the result register; key and
//   stick events give no result and change the rows as they leave the stage.
// Reset: synchronous, active low; all rows go to 0x1f (no key down), both
//   stick maps go to their default layouts, pipeline valids clear.
// ----------------------------------------------------------------------------
module keyboard_matrix_with_joystick_remap_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [kmjr_pkg::MAP_W-1:0]    cfg_wdata,
  // event input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [kmjr_pkg::KEY_W-1:0]    in_key_index,
  input  logic                          in_stick_select,
  input  logic [2:0]                    in_stick_button,
  input  logic                          in_pressed,
  input  logic [kmjr_pkg::NUM_ROWS-1:0] in_addr_high,
  // read result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kmjr_pkg::NUM_COLS-1:0] out_key_data
);
  import kmjr_pkg::*;

  // Event stage register
  logic                stg_valid_r, stg_valid_nxt;
  logic [1:0]          stg_op_r;
  logic [KEY_W-1:0]    stg_key_index_r;
  logic                stg_stick_select_r;
  logic [2:0]          stg_stick_button_r;
  logic                stg_pressed_r;
  logic [NUM_ROWS-1:0] stg_addr_high_r;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic [NUM_COLS-1:0] out_key_data_r;

  logic                in_xfer;
  logic                stg_is_read;
  logic                stg_advance;
  logic [NUM_COLS-1:0] rd_data;
  key_upd_t            upd;

  assign in_xfer     = in_valid && in_ready;
  assign stg_is_read = (stg_op_r == OP_READ);

  // A read can only leave the stage when the result register is free or
  // draining this cycle; every other event retires unconditionally.
  assign stg_advance = stg_valid_r && (!stg_is_read || !out_valid_r || out_ready);
  assign in_ready    = !stg_valid_r || stg_advance;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_ready) stg_valid_nxt = in_valid;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (stg_advance && stg_is_read) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_op_r           <= in_op;
      stg_key_index_r    <= in_key_index;
      stg_stick_select_r <= in_stick_select;
      stg_stick_button_r <= in_stick_button;
      stg_pressed_r      <= in_pressed;
      stg_addr_high_r    <= in_addr_high;
    end
    if (stg_advance && stg_is_read) begin
      out_key_data_r <= rd_data;
    end
  end

  // Only a retiring event may touch the rows, so each update lands once.
  kmjr_keymap u_keymap (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .evt_valid        (stg_advance),
    .evt_op           (stg_op_r),
    .evt_key_index    (stg_key_index_r),
    .evt_stick_select (stg_stick_select_r),
    .evt_stick_button (stg_stick_button_r),
    .evt_pressed      (stg_pressed_r),
    .upd              (upd)
  );

  kmjr_row_store u_rows (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .addr_high (stg_addr_high_r),
    .key_data  (rd_data)
  );

  assign out_valid    = out_valid_r;
  assign out_key_data = out_key_data_r;

endmodule

[src/kmjr_keymap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmjr_keymap
// Joystick map registers and key index selection for key and stick events.
// ----------------------------------------------------------------------------
module kmjr_keymap (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [kmjr_pkg::MAP_W-1:0]  cfg_wdata,
  input  logic                        evt_valid,
  input  logic [1:0]                  evt_op,
  input  logic [kmjr_pkg::KEY_W-1:0]  evt_key_index,
  input  logic                        evt_stick_select,
  input  logic [2:0]                  evt_stick_button,
  input  logic                        evt_pressed,
  output kmjr_pkg::key_upd_t          upd
);
  import kmjr_pkg::*;

  logic [MAP_W-1:0] stick0_map_r;
  logic [MAP_W-1:0] stick1_map_r;
  logic [MAP_W-1:0] map_sel;
  logic [KEY_W-1:0] stick_key;
  logic             btn_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick0_map_r <= STICK0_MAP_RST;
      stick1_map_r <= STICK1_MAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STICK0: stick0_map_r <= cfg_wdata;
        CFG_STICK1: stick1_map_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  assign map_sel = evt_stick_select ? stick1_map_r : stick0_map_r;

  always_comb begin
    btn_ok    = 1'b1;
    stick_key = map_sel[5:0];
    unique case (evt_stick_button)
      3'd0:    stick_key = map_sel[5:0];
      3'd1:    stick_key = map_sel[11:6];
      3'd2:    stick_key = map_sel[17:12];
      3'd3:    stick_key = map_sel[23:18];
      3'd4:    stick_key = map_sel[29:24];
      default: btn_ok    = 1'b0;
    endcase
  end

  always_comb begin
    upd.down = evt_pressed;
    upd.key  = evt_key_index;
    upd.en   = 1'b0;
    if (evt_valid) begin
      priority if (evt_op == OP_KEY) begin
        upd.en = 1'b1;
      end else if (evt_op == OP_STICK) begin
        upd.key = stick_key;
        upd.en  = btn_ok;
      end else begin
        upd.en = 1'b0;
      end
    end
  end

endmodule

[src/kmjr_row_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmjr_row_store
// Eight 5-bit active-low matrix rows: key updates and the address-select AND.
// ----------------------------------------------------------------------------
module kmjr_row_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kmjr_pkg::key_upd_t            upd,
  input  logic [kmjr_pkg::NUM_ROWS-1:0] addr_high,
  output logic [kmjr_pkg::NUM_COLS-1:0] key_data
);
  import kmjr_pkg::*;

  logic [NUM_COLS-1:0] rows_r   [NUM_ROWS];
  logic [NUM_COLS-1:0] col_mask;
  logic [5:0]          pos;
  logic [2:0]          row_idx;
  logic                key_ok;

  assign key_ok   = (upd.key < KEY_W'(NUM_KEYS));
  assign pos      = key_ok ? KEY_POS[upd.key] : 6'd0;
  assign row_idx  = pos[5:3];
  assign col_mask = NUM_COLS'(1) << pos[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        rows_r[r] <= ROW_MASK;
      end
    end else if (upd.en && key_ok) begin
      if (upd.down) begin
        rows_r[row_idx] <= rows_r[row_idx] & ~col_mask;
      end else begin
        rows_r[row_idx] <= rows_r[row_idx] | col_mask;
      end
    end
  end

  // low address bit selects its row
  always_comb begin
    key_data = ROW_MASK;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (!addr_high[r]) key_data = key_data & rows_r[r];
    end
  end

endmodule
